FILE: rtl/nfsa_pkg.sv
// shared constants, codes and types of the next-fit slot allocator
package nfsa_pkg;

	localparam int POOL_SLOTS_DEF = 1024;

	localparam int WORD_BITS  = 32;
	localparam int BIT_W      = 5;
	localparam int FUNC_W     = 1;
	localparam int COUNT_W    = 11;
	localparam int SLOT_IN_W  = 11;
	localparam int SLOT_OUT_W = 10;
	localparam int STATUS_W   = 3;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_ONE = 11'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED    = 3'd0,
		ST_FULL         = 3'd1,
		ST_BAD_COUNT    = 3'd2,
		ST_FREED        = 3'd3,
		ST_FREE_IGNORED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FREE_RD,
		S_FREE_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] idx;
	} scan_res_t;

endpackage

FILE: rtl/nfsa_bitmap_ram.sv
// used-slot bitmap storage, one write port and one registered read port
module nfsa_bitmap_ram #(
	parameter int WORDS  = 32,
	parameter int ADDR_W = 5
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [ADDR_W-1:0]             wr_addr,
	input  logic [nfsa_pkg::WORD_BITS-1:0] wr_data,
	input  logic                          rd_en,
	input  logic [ADDR_W-1:0]             rd_addr,
	output logic [nfsa_pkg::WORD_BITS-1:0] rd_data
);
	import nfsa_pkg::*;

	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/nfsa_word_scan.sv
// find-first-free unit over one bitmap word
module nfsa_word_scan (
	input  logic [nfsa_pkg::WORD_BITS-1:0] word,
	input  logic [nfsa_pkg::WORD_BITS-1:0] mask,
	output nfsa_pkg::scan_res_t            res
);
	import nfsa_pkg::*;

	logic [WORD_BITS-1:0] free_bits;

	always_comb begin
		free_bits = ~word & mask;
		res.found = |free_bits;
		res.idx   = '0;
		// lowest free bit wins
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				res.idx = BIT_W'(i);
			end
		end
	end

endmodule

FILE: rtl/next_fit_slot_allocator.sv
// next-fit slot allocator top level: sequencer, hint and result register
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid in_ready func count slot_in | request beat into block
//  out     | out_valid out_ready slot_out status  | result beat out of block
//          | wrapped                              |
//
// an allocate walks the bitmap one 32-bit word per cycle through the single
// find-first-free unit, wrapping to word 0 when the search from the hint
// finds nothing. a free is a read-modify-write of one word. after reset a
// clearing pass writes ceil(POOL_SLOTS/32) words with in_ready low. the block
// takes one request at a time and holds a finished beat in the output register
// while out_ready is low.
module next_fit_slot_allocator #(
	parameter int POOL_SLOTS = nfsa_pkg::POOL_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [nfsa_pkg::FUNC_W-1:0]     func,
	input  logic [nfsa_pkg::COUNT_W-1:0]    count,
	input  logic [nfsa_pkg::SLOT_IN_W-1:0]  slot_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [nfsa_pkg::SLOT_OUT_W-1:0] slot_out,
	output logic [nfsa_pkg::STATUS_W-1:0]   status,
	output logic                            wrapped
);
	import nfsa_pkg::*;

	localparam int WORDS     = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int WA        = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int HW        = $clog2(POOL_SLOTS + 1);
	localparam int CW        = (HW > SLOT_IN_W) ? HW : SLOT_IN_W;
	localparam int LAST_BITS = POOL_SLOTS - (WORDS - 1) * WORD_BITS;
	localparam logic [WA-1:0] LAST_WORD = WA'(WORDS - 1);
	localparam logic [WORD_BITS-1:0] LAST_MASK =
		WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);

	state_t state_q, state_d;

	logic [WA-1:0]        clear_q;
	logic [HW-1:0]        hint_q;
	logic                 phase2_q;
	logic [WA-1:0]        issue_q;
	logic [WA-1:0]        stop_q;
	logic                 issue_more_q;
	logic                 ev_valid_s1;
	logic [WA-1:0]        ev_addr_s1;
	logic                 ev_last_s1;
	logic [HW-1:0]        slot_q;
	logic [SLOT_OUT_W-1:0] res_slot_q;
	status_t              res_status_q;
	logic                 res_wrap_q;
	logic                 out_valid_q;
	logic [SLOT_OUT_W-1:0] slot_out_q;
	status_t              status_q;
	logic                 wrapped_q;

	logic                 rd_en, wr_en, load_out;
	logic [WA-1:0]        rd_addr, wr_addr;
	logic [WORD_BITS-1:0] wr_data, rd_data;
	logic [WORD_BITS-1:0] scan_mask;
	scan_res_t            scan;

	logic [CW-1:0]        slot_in_x;
	logic                 slot_ok, count_ok, accept;
	logic [WA-1:0]        hint_word, slot_word;
	logic [BIT_W-1:0]     hint_bit, slot_bit;
	logic [HW-1:0]        grant_slot;
	logic                 grant, restart;

	assign slot_in_x = CW'(slot_in);
	assign slot_ok   = slot_in_x < CW'(POOL_SLOTS);
	assign count_ok  = count == COUNT_ONE;
	assign accept    = in_valid && in_ready;
	assign hint_word = WA'(hint_q >> BIT_W);
	assign hint_bit  = BIT_W'(hint_q);
	assign slot_word = WA'(slot_q >> BIT_W);
	assign slot_bit  = BIT_W'(slot_q);
	assign in_ready  = state_q == S_IDLE;

	// only the hint word is trimmed below the hint, and only before the wrap
	always_comb begin
		scan_mask = '1;
		if (!phase2_q && ev_addr_s1 == hint_word) begin
			scan_mask = scan_mask << hint_bit;
		end
		if (ev_addr_s1 == LAST_WORD) begin
			scan_mask = scan_mask & LAST_MASK;
		end
	end

	nfsa_word_scan u_scan (
		.word (rd_data),
		.mask (scan_mask),
		.res  (scan)
	);

	nfsa_bitmap_ram #(
		.WORDS  (WORDS),
		.ADDR_W (WA)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign grant_slot = HW'({ev_addr_s1, scan.idx});
	assign grant      = state_q == S_SCAN && ev_valid_s1 && scan.found;
	assign restart    = state_q == S_SCAN && ev_valid_s1 && !scan.found && ev_last_s1
		&& !phase2_q && hint_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = issue_q;
		wr_en    = 1'b0;
		wr_addr  = ev_addr_s1;
		wr_data  = rd_data | (WORD_BITS'(1) << scan.idx);
		load_out = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clear_q;
				wr_data = '0;
				if (clear_q == LAST_WORD) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					unique case (func)
						FUNC_ALLOC: state_d = count_ok ? S_SCAN : S_DONE;
						FUNC_FREE:  state_d = (count_ok && slot_ok) ? S_FREE_RD : S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				rd_en = issue_more_q;
				if (ev_valid_s1) begin
					if (scan.found) begin
						wr_en   = 1'b1;
						state_d = S_DONE;
					end else if (ev_last_s1 && (phase2_q || hint_q == '0)) begin
						state_d = S_DONE;
					end
				end
			end
			S_FREE_RD: begin
				rd_en   = 1'b1;
				rd_addr = slot_word;
				state_d = S_FREE_WR;
			end
			S_FREE_WR: begin
				wr_en   = 1'b1;
				wr_addr = slot_word;
				wr_data = rd_data & ~(WORD_BITS'(1) << slot_bit);
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q      <= '0;
			hint_q       <= '0;
			phase2_q     <= 1'b0;
			issue_q      <= '0;
			stop_q       <= '0;
			issue_more_q <= 1'b0;
			ev_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clear_q <= clear_q + WA'(1);
			end
			ev_valid_s1 <= rd_en && state_q == S_SCAN && state_d == S_SCAN;
			if (accept && func == FUNC_ALLOC && count_ok) begin
				issue_more_q <= 1'b1;
				// hint at the pool end: nothing above it, go straight to the wrap
				if (hint_q == HW'(POOL_SLOTS)) begin
					phase2_q <= 1'b1;
					issue_q  <= '0;
					stop_q   <= WA'((hint_q - HW'(1)) >> BIT_W);
				end else begin
					phase2_q <= 1'b0;
					issue_q  <= hint_word;
					stop_q   <= LAST_WORD;
				end
			end else if (restart) begin
				phase2_q     <= 1'b1;
				issue_q      <= '0;
				stop_q       <= WA'((hint_q - HW'(1)) >> BIT_W);
				issue_more_q <= 1'b1;
			end else if (state_q == S_SCAN && rd_en) begin
				issue_q      <= issue_q + WA'(1);
				issue_more_q <= issue_q != stop_q;
			end
			if (grant) begin
				hint_q <= grant_slot + HW'(1);
			end else if (state_q == S_FREE_WR && slot_q < hint_q) begin
				hint_q <= slot_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ev_addr_s1 <= issue_q;
		ev_last_s1 <= issue_q == stop_q;
		if (accept) begin
			slot_q     <= HW'(slot_in_x);
			res_slot_q <= '0;
			res_wrap_q <= 1'b0;
			unique case (func)
				FUNC_ALLOC: res_status_q <= count_ok ? ST_FULL : ST_BAD_COUNT;
				FUNC_FREE:  res_status_q <= (count_ok && slot_ok) ? ST_FREED : ST_FREE_IGNORED;
			endcase
		end
		if (grant) begin
			res_slot_q   <= SLOT_OUT_W'(grant_slot);
			res_status_q <= ST_ALLOCATED;
			res_wrap_q   <= phase2_q;
		end
		if (load_out) begin
			slot_out_q <= res_slot_q;
			status_q   <= res_status_q;
			wrapped_q  <= res_wrap_q;
		end
	end

	assign out_valid = out_valid_q;
	assign slot_out  = slot_out_q;
	assign status    = status_q;
	assign wrapped   = wrapped_q;

`ifndef SYNTHESIS
	a_rd_wr_apart: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en |-> rd_addr != wr_addr)
		else $error("bitmap read and write hit the same word");

	a_hint_range: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= HW'(POOL_SLOTS))
		else $error("search hint beyond pool end");

	a_grant_hint: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && res_status_q == ST_ALLOCATED
		|-> SLOT_OUT_W'(hint_q - HW'(1)) == res_slot_q)
		else $error("hint not just past granted slot");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one in flight");

	a_wrap_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wrapped |-> status == ST_ALLOCATED)
		else $error("wrapped flag on a non-allocate result");
`endif

endmodule
